// ----- hw/rtl/slcd_pkg.sv -----
// shared types and constants of the sync/length/checksum deframer
package slcd_pkg;

   localparam logic [7:0] SYNC_FIRST        = 8'hFF;
   localparam logic [7:0] SYNC_SECOND       = 8'h55;
   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd127;

   typedef enum logic [1:0] {
      PHASE_HUNT = 2'd0,
      PHASE_SYNC = 2'd1,
      PHASE_LEN  = 2'd2,
      PHASE_BODY = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_GOOD      = 2'd0,
      STATUS_MISMATCH  = 2'd1,
      STATUS_ZERO_LEN  = 2'd2,
      STATUS_TOO_LONG  = 2'd3
   } status_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_done;
      status_type frame_status;
      logic [7:0] frame_payload_length;
      logic       in_frame;
   } rsp_type;

endpackage

// ----- hw/rtl/slcd_if.sv -----
// channel interfaces of the deframer: received bytes, results, register write
interface slcd_req_if import slcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_rsp_if import slcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic       frame_done;
   logic [1:0] frame_status;
   logic [7:0] frame_payload_length;
   logic       in_frame;

   modport source (output valid, output payload_valid, output payload_byte,
                   output payload_index, output frame_done, output frame_status,
                   output frame_payload_length, output in_frame, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input payload_index, input frame_done, input frame_status,
                   input frame_payload_length, input in_frame, output ready);
endinterface

interface slcd_csr_if import slcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] max_payload;

   modport source (output valid, output max_payload, input ready);
   modport sink   (input valid, input max_payload, output ready);
endinterface

// ----- hw/rtl/sync_length_checksum_deframer.sv -----
// top level of the sync/length/checksum deframer
//
// req_ch carries one received link byte per transaction. The parser hunts
// for the sync pair 0xFF 0x55, takes the next byte as the length (payload
// count plus one checksum byte), then streams the payload out with its index
// and checks the 8-bit additive sum (length plus payload) against the last
// byte. A zero length or a payload longer than max_payload aborts the frame.
// rsp_ch gives exactly one result transaction per received byte.
// csr_ch writes max_payload; it is always ready and should only be used
// while no byte is in flight.
// Each result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while rsp_ch is ready, set by the single result register.
// The parser state updates in one step of small compare/add logic.
// Reset: parser back to hunting, result register empty, max_payload 127.
// Stall: while a result waits on rsp_ch, a new byte is accepted only in the
// cycle the waiting result is taken, so req_ch.ready follows rsp_ch.ready.
module sync_length_checksum_deframer import slcd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   slcd_req_if.sink   req_ch,
   slcd_rsp_if.source rsp_ch,
   slcd_csr_if.sink   csr_ch
);

   phase_type  phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] max_payload_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       accept;
   logic [7:0] rx;
   logic [7:0] len_minus_one;
   logic [7:0] body_plen;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rx           = req_ch.rx_byte;
   assign len_minus_one = rx - 8'd1;
   assign body_plen     = length_ff - 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_HUNT;
         count_ff       <= '0;
         length_ff      <= '0;
         sum_ff         <= '0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            max_payload_ff <= csr_ch.max_payload;
         end
         if (accept) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            length_ff <= length_in;
            sum_ff    <= sum_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      rsp_data_in = '0;
      unique case (phase_ff)
         PHASE_HUNT: begin
            if (rx == SYNC_FIRST) begin
               phase_in = PHASE_SYNC;
            end
         end
         PHASE_SYNC: begin
            priority if (rx == SYNC_FIRST) begin
               phase_in = PHASE_SYNC;
            end else if (rx == SYNC_SECOND) begin
               phase_in = PHASE_LEN;
            end else begin
               phase_in = PHASE_HUNT;
            end
         end
         PHASE_LEN: begin
            length_in = rx;
            count_in  = '0;
            sum_in    = rx;
            priority if (rx == 8'd0) begin
               rsp_data_in.frame_done   = 1'b1;
               rsp_data_in.frame_status = STATUS_ZERO_LEN;
               phase_in = PHASE_HUNT;
            end else if (len_minus_one > max_payload_ff) begin
               rsp_data_in.frame_done           = 1'b1;
               rsp_data_in.frame_status         = STATUS_TOO_LONG;
               rsp_data_in.frame_payload_length = len_minus_one;
               phase_in = PHASE_HUNT;
            end else begin
               phase_in = PHASE_BODY;
            end
         end
         PHASE_BODY: begin
            if (length_ff != 8'd0 && count_ff < body_plen) begin
               rsp_data_in.payload_valid = 1'b1;
               rsp_data_in.payload_byte  = rx;
               rsp_data_in.payload_index = count_ff;
               sum_in   = sum_ff + rx;
               count_in = count_ff + 8'd1;
            end else begin
               rsp_data_in.frame_done   = 1'b1;
               rsp_data_in.frame_status = (sum_ff == rx) ? STATUS_GOOD : STATUS_MISMATCH;
               rsp_data_in.frame_payload_length = (length_ff != 8'd0) ? body_plen : 8'd0;
               phase_in = PHASE_HUNT;
            end
         end
         default: begin
            phase_in = PHASE_HUNT;
         end
      endcase
      rsp_data_in.in_frame = (phase_in == PHASE_LEN) || (phase_in == PHASE_BODY);
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.payload_valid        = rsp_data_ff.payload_valid;
   assign rsp_ch.payload_byte         = rsp_data_ff.payload_byte;
   assign rsp_ch.payload_index        = rsp_data_ff.payload_index;
   assign rsp_ch.frame_done           = rsp_data_ff.frame_done;
   assign rsp_ch.frame_status         = rsp_data_ff.frame_status;
   assign rsp_ch.frame_payload_length = rsp_data_ff.frame_payload_length;
   assign rsp_ch.in_frame             = rsp_data_ff.in_frame;

endmodule

// ----- hw/rtl/slcd_checker.sv -----
// port-level checker of the deframer and its bind to the top level
module slcd_checker import slcd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       payload_valid,
   input logic [7:0] payload_byte,
   input logic       frame_done,
   input logic [1:0] frame_status,
   input logic [7:0] frame_payload_length,
   input logic       in_frame
);

   // a held result keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_byte)
         && $stable(frame_status) && $stable(frame_payload_length))
      else $error("stalled result changed");

   // every accepted byte yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte gave no result");

   // a result is never both payload and frame end; payload keeps the frame open and a frame end closes it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(payload_valid && frame_done)
         && (!payload_valid || in_frame) && (!frame_done || !in_frame))
      else $error("inconsistent frame flags");

   // a zero-length abort reports no payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done && frame_status == STATUS_ZERO_LEN
         |-> frame_payload_length == 8'd0)
      else $error("zero-length abort with nonzero length");

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .payload_valid        (rsp_ch.payload_valid),
   .payload_byte         (rsp_ch.payload_byte),
   .frame_done           (rsp_ch.frame_done),
   .frame_status         (rsp_ch.frame_status),
   .frame_payload_length (rsp_ch.frame_payload_length),
   .in_frame             (rsp_ch.in_frame)
);

// ----- bench/tb_sync_length_checksum_deframer.sv -----
// testbench of the deframer: framed and noisy byte streams checked against an in-bench predictor
`timescale 1ns / 1ps

module tb_sync_length_checksum_deframer import slcd_pkg::*;;

   logic clock = 1'b0;
   logic reset;

   slcd_req_if req_ch ();
   slcd_rsp_if rsp_ch ();
   slcd_csr_if csr_ch ();

   sync_length_checksum_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   logic [7:0]  outgoing_bytes [$];
   rsp_type     pending_results [$];

   phase_type   exp_phase = PHASE_HUNT;
   logic [7:0]  exp_taken = '0;
   logic [7:0]  exp_len = '0;
   logic [7:0]  exp_sum = '0;
   logic [7:0]  exp_limit = MAX_PAYLOAD_RESET;

   int unsigned mismatches = 0;
   int unsigned sent_bytes = 0;
   int unsigned payload_seen = 0;
   int unsigned settings_used = 0;
   int unsigned status_seen [4] = '{0, 0, 0, 0};
   int          cur_max = int'(MAX_PAYLOAD_RESET);
   bit          quiet = 1'b0;
   bit          hold_trigger = 1'b0;
   bit          hold_ack;
   int          send_gap;
   int          stall_left;
   int          hold_left;

   logic [7:0] opening_bytes [0:23] = '{
      SYNC_FIRST, SYNC_SECOND, 8'h00,
      SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, 8'h01, 8'h01,
      SYNC_FIRST, SYNC_SECOND, 8'h03, 8'h00, 8'hFF, 8'h02,
      SYNC_FIRST, SYNC_SECOND, 8'h02, 8'h7E, 8'h00,
      SYNC_FIRST, 8'h12,
      SYNC_FIRST, SYNC_SECOND, 8'h81
   };

   task automatic note_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
   endtask

   function automatic rsp_type deframe_byte(input logic [7:0] b);
      rsp_type    r;
      logic [7:0] plen;
      r = '0;
      case (exp_phase)
         PHASE_HUNT: begin
            if (b == SYNC_FIRST) exp_phase = PHASE_SYNC;
         end
         PHASE_SYNC: begin
            if (b == SYNC_FIRST) exp_phase = PHASE_SYNC;
            else if (b == SYNC_SECOND) exp_phase = PHASE_LEN;
            else exp_phase = PHASE_HUNT;
         end
         PHASE_LEN: begin
            exp_len = b;
            exp_taken = '0;
            exp_sum = b;
            plen = b - 8'd1;
            if (b == 8'd0) begin
               r.frame_done = 1'b1;
               r.frame_status = STATUS_ZERO_LEN;
               exp_phase = PHASE_HUNT;
            end else if (plen > exp_limit) begin
               r.frame_done = 1'b1;
               r.frame_status = STATUS_TOO_LONG;
               r.frame_payload_length = plen;
               exp_phase = PHASE_HUNT;
            end else begin
               exp_phase = PHASE_BODY;
            end
         end
         default: begin
            plen = exp_len - 8'd1;
            if (exp_len != 8'd0 && exp_taken < plen) begin
               r.payload_valid = 1'b1;
               r.payload_byte = b;
               r.payload_index = exp_taken;
               exp_sum = exp_sum + b;
               exp_taken = exp_taken + 8'd1;
            end else begin
               r.frame_done = 1'b1;
               r.frame_status = (exp_sum == b) ? STATUS_GOOD : STATUS_MISMATCH;
               r.frame_payload_length = (exp_len != 8'd0) ? plen : 8'd0;
               exp_phase = PHASE_HUNT;
            end
         end
      endcase
      r.in_frame = (exp_phase == PHASE_LEN || exp_phase == PHASE_BODY);
      return r;
   endfunction

   // result check first, then the prediction for the byte taken at this edge
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         exp_phase = PHASE_HUNT;
         exp_taken = '0;
         exp_len = '0;
         exp_sum = '0;
         exp_limit = MAX_PAYLOAD_RESET;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               note_mismatch("result transaction with nothing expected", 8'd0, 8'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.payload_valid !== want.payload_valid)
                  note_mismatch("payload_valid", 8'(rsp_ch.payload_valid),
                                8'(want.payload_valid));
               if (rsp_ch.payload_byte !== want.payload_byte)
                  note_mismatch("payload_byte", rsp_ch.payload_byte, want.payload_byte);
               if (rsp_ch.payload_index !== want.payload_index)
                  note_mismatch("payload_index", rsp_ch.payload_index, want.payload_index);
               if (rsp_ch.frame_done !== want.frame_done)
                  note_mismatch("frame_done", 8'(rsp_ch.frame_done), 8'(want.frame_done));
               if (rsp_ch.frame_status !== want.frame_status)
                  note_mismatch("frame_status", 8'(rsp_ch.frame_status),
                                8'(want.frame_status));
               if (rsp_ch.frame_payload_length !== want.frame_payload_length)
                  note_mismatch("frame_payload_length", rsp_ch.frame_payload_length,
                                want.frame_payload_length);
               if (rsp_ch.in_frame !== want.in_frame)
                  note_mismatch("in_frame", 8'(rsp_ch.in_frame), 8'(want.in_frame));
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            exp_limit = csr_ch.max_payload;
         if (req_ch.valid && req_ch.ready) begin
            want = deframe_byte(req_ch.rx_byte);
            pending_results.push_back(want);
            if (want.frame_done) status_seen[want.frame_status]++;
            if (want.payload_valid) payload_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.rx_byte <= '0;
         send_gap <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            send_gap <= $urandom_range(0, 18);
            req_ch.valid <= 1'b0;
         end else if (outgoing_bytes.size() != 0) begin
            req_ch.valid <= 1'b1;
            req_ch.rx_byte <= outgoing_bytes.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_ack <= hold_trigger;
      end else if (hold_ack != hold_trigger) begin
         hold_ack <= hold_trigger;
         hold_left <= 80;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      outgoing_bytes.push_back(b);
      sent_bytes++;
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0, 1:    return SYNC_FIRST;
         2:       return SYNC_SECOND;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic add_header(input logic [7:0] len);
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      push_byte(len);
   endtask

   task automatic add_frame(input int plen, input bit corrupt);
      logic [7:0] sum;
      logic [7:0] d;
      sum = 8'(plen + 1);
      add_header(sum);
      repeat (plen) begin
         d = 8'($urandom);
         push_byte(d);
         sum = sum + d;
      end
      push_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   task automatic add_random_traffic(input int unsigned budget);
      int unsigned stop_at;
      int          pick;
      int          plen;
      stop_at = sent_bytes + budget;
      while (sent_bytes < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            plen = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 48);
            if (plen > cur_max) plen = $urandom_range(0, cur_max);
            add_frame(plen, $urandom_range(0, 4) == 0);
         end else if (pick < 75) begin
            add_header(8'd0);
         end else if (pick < 82) begin
            if (cur_max < 254) add_header(8'($urandom_range(cur_max + 2, 255)));
         end else if (pick < 91) begin
            repeat ($urandom_range(1, 4)) push_byte(noise_byte());
         end else begin
            // repeated first sync bytes, then a noise byte or a cut-off frame
            repeat ($urandom_range(1, 3)) push_byte(SYNC_FIRST);
            if ($urandom_range(0, 1) != 0) begin
               plen = $urandom_range(1, 9);
               if (plen > cur_max) plen = cur_max;
               push_byte(SYNC_SECOND);
               push_byte(8'(plen + 1));
               repeat ($urandom_range(0, plen)) push_byte(8'($urandom));
            end else begin
               push_byte(noise_byte());
            end
         end
      end
   endtask

   task automatic wait_drained();
      int unsigned spent;
      spent = 0;
      do begin
         @(negedge clock);
         spent++;
      end while ((outgoing_bytes.size() != 0 || req_ch.valid || pending_results.size() != 0)
                 && spent < 5000);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_max_payload(input logic [7:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.max_payload <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      cur_max = int'(value);
      settings_used++;
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.max_payload = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_max_payload(MAX_PAYLOAD_RESET);
      foreach (opening_bytes[i]) push_byte(opening_bytes[i]);
      add_random_traffic(80);
      wait_drained();

      set_max_payload(8'd1);
      add_frame(1, 1'b0);
      add_header(8'd3);
      add_random_traffic(100);
      wait_drained();

      set_max_payload(8'd254);
      add_frame(254, 1'b0);
      add_header(8'd0);
      add_random_traffic(100);
      wait_drained();

      set_max_payload(8'd0);
      add_frame(0, 1'b0);
      add_header(8'd2);
      add_random_traffic(80);
      wait_drained();

      set_max_payload(8'd255);
      add_frame(40, 1'b1);
      add_random_traffic(100);
      wait_drained();

      set_max_payload(8'($urandom_range(2, 253)));
      add_frame(cur_max, 1'b0);
      add_header(8'(cur_max + 2));
      hold_trigger = ~hold_trigger;
      add_random_traffic(100);
      wait_drained();
      add_random_traffic(70);
      wait_drained();

      set_max_payload(MAX_PAYLOAD_RESET);
      quiet = 1'b1;
      add_random_traffic(140);
      wait_drained();

      if (pending_results.size() != 0)
         note_mismatch("results never delivered", 8'(pending_results.size()), 8'd0);
      $display("%0d bytes sent over %0d max_payload settings, %0d payload bytes streamed",
               sent_bytes, settings_used, payload_seen);
      $display("frames: %0d good, %0d bad checksum, %0d zero length, %0d too long",
               status_seen[STATUS_GOOD], status_seen[STATUS_MISMATCH],
               status_seen[STATUS_ZERO_LEN], status_seen[STATUS_TOO_LONG]);
      if (mismatches == 0)
         $display("sync_length_checksum_deframer: match");
      else
         $display("sync_length_checksum_deframer: mismatch");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("sync_length_checksum_deframer: mismatch");
      $finish;
   end

endmodule

// ----- sync_length_checksum_deframer.f -----
hw/rtl/slcd_pkg.sv
hw/rtl/slcd_if.sv
hw/rtl/sync_length_checksum_deframer.sv
hw/rtl/slcd_checker.sv
bench/tb_sync_length_checksum_deframer.sv
